FILE: design/setq_pkg.sv
// Shared types and constants for the sorted expiry timer queue.
// No dependencies; every module of the block imports this package.
package setq_pkg;
  localparam int TIMER_SLOTS = 16;
  localparam int TIME_WIDTH  = 32;
  localparam int HW          = 4;   // handle field width
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int FIFO_DEPTH  = 2;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_ADJUST = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_QUEUED  = 2'd1,
    ST_NOT_Q   = 2'd2
  } status_t;

  // Operation handed from front to back
  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,   // status only, no queue change
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,   // remove, optionally reinsert
    OP_DRAIN  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BS_IDLE   = 2'd0,
    BS_REMOVE = 2'd1,
    BS_INSERT = 2'd2,
    BS_DRAIN  = 2'd3
  } bstate_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  handle;
    logic [31:0] expire_time;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic       expired_valid;
    logic [3:0] expired_handle;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    op_t                   op;
    logic                  reinsert;
    logic [HW-1:0]         handle;
    logic [TIME_WIDTH-1:0] tval;
    status_t               status;
  } job_t;
endpackage

FILE: design/setq_front.sv
// Front part: accepts commands, checks handle state, emits jobs.
// Depends on setq_pkg.
module setq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  setq_pkg::in_item_t in_data,
  output logic               job_valid,
  input  logic               job_ready,
  output setq_pkg::job_t     job_data,
  input  logic               clr_valid,
  input  logic [setq_pkg::HW-1:0] clr_handle,
  input  logic               drain_done
);
  import setq_pkg::*;

  logic [TIMER_SLOTS-1:0] queued_r, queued_nxt;
  logic                   drain_r, drain_nxt;
  logic                   in_range;
  logic                   hq;
  logic [SLOT_W-1:0]      slot;

  assign slot      = in_data.handle[SLOT_W-1:0];
  assign in_range  = ({{(32-HW){1'b0}}, in_data.handle} < TIMER_SLOTS);
  assign hq        = in_range && queued_r[slot];
  // Hold new commands while a tick is still draining the chain
  assign in_ready  = job_ready && !drain_r;
  assign job_valid = in_valid && !drain_r;

  // Classify the command
  always_comb begin
    job_data.op       = OP_REPORT;
    job_data.reinsert = 1'b0;
    job_data.handle   = in_data.handle;
    job_data.tval     = TIME_WIDTH'(in_data.expire_time);
    job_data.status   = ST_OK;
    if (in_data.command == CMD_TICK) begin
      job_data.op   = OP_DRAIN;
      job_data.tval = TIME_WIDTH'(in_data.now_time);
    end else if (!in_range) begin
      job_data.status = ST_NOT_Q;
    end else if (in_data.command == CMD_ADD) begin
      if (hq) job_data.status = ST_QUEUED;
      else    job_data.op     = OP_INSERT;
    end else if (!hq) begin
      job_data.status = ST_NOT_Q;
    end else begin
      job_data.op       = OP_REMOVE;
      job_data.reinsert = (in_data.command == CMD_ADJUST);
    end
  end

  // Track which handles are queued and whether a drain is in flight
  always_comb begin
    queued_nxt = queued_r;
    drain_nxt  = drain_r;
    if (clr_valid) queued_nxt[clr_handle[SLOT_W-1:0]] = 1'b0;
    if (drain_done) drain_nxt = 1'b0;
    if (in_valid && in_ready) begin
      if (in_data.command == CMD_TICK) drain_nxt = 1'b1;
      else if (in_range) begin
        if (in_data.command == CMD_ADD) queued_nxt[slot] = 1'b1;
        else if (in_data.command == CMD_DELETE) queued_nxt[slot] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queued_r <= '0;
      drain_r  <= 1'b0;
    end else begin
      queued_r <= queued_nxt;
      drain_r  <= drain_nxt;
    end
  end
endmodule

FILE: design/setq_fifo.sv
// Short job queue between front and back parts.
// Depends on setq_pkg.
module setq_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  setq_pkg::job_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output setq_pkg::job_t  rd_data
);
  import setq_pkg::*;
  localparam int PW = $clog2(FIFO_DEPTH);

  job_t            mem_r [FIFO_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;
  logic            wr_en, rd_en;

  assign wr_ready = (cnt_r < (PW+1)'(FIFO_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  // Store and advance pointers
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr_en) - (PW+1)'(rd_en);
    end
  end
endmodule

FILE: design/setq_back.sv
// Back part: sorted cell chain doing insert, remove and drain.
// Depends on setq_pkg.
module setq_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  setq_pkg::job_t       job_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output setq_pkg::out_item_t  out_data,
  output logic                 clr_valid,
  output logic [setq_pkg::HW-1:0] clr_handle,
  output logic                 drain_done
);
  import setq_pkg::*;

  logic [HW-1:0]         hnd_r [TIMER_SLOTS];
  logic [TIME_WIDTH-1:0] exp_r [TIMER_SLOTS];
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  bstate_t               st_r, st_nxt;
  job_t                  job_r;
  logic                  job_ld;
  logic                  ov_r;
  out_item_t             od_r;
  logic                  obuf_free;
  logic                  emit;
  out_item_t             emit_d;
  logic                  drained_r;
  logic [TIMER_SLOTS-1:0] live, le_mask, hit_mask;
  logic [TIMER_SLOTS-1:0] ins_shift, rem_shift;
  logic                  do_ins, do_rem, do_pop;
  logic                  head_exp;
  logic [SLOT_W-1:0]     ins_pos;

  assign obuf_free = !ov_r || out_ready;

  // Per-cell compares across the chain
  always_comb begin
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      live[i]     = (CNT_W'(i) < cnt_r);
      le_mask[i]  = live[i] && (exp_r[i] <= job_r.tval);
      hit_mask[i] = live[i] && (hnd_r[i] == job_r.handle);
    end
    ins_pos = '0;
    for (int i = 0; i < TIMER_SLOTS; i++)
      if (le_mask[i]) ins_pos = SLOT_W'(i + 1 < TIMER_SLOTS ? i + 1 : i);
    // cells at or after the insert point shift up; hits and after shift down
    rem_shift[0] = hit_mask[0];
    for (int i = 0; i < TIMER_SLOTS; i++)
      ins_shift[i] = !le_mask[i];
    for (int i = 1; i < TIMER_SLOTS; i++)
      rem_shift[i] = rem_shift[i-1] || hit_mask[i];
  end

  assign head_exp = (cnt_r != '0) && (exp_r[0] <= job_r.tval);

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BS_IDLE: if (job_valid) begin
        unique case (job_data.op)
          OP_INSERT: st_nxt = BS_INSERT;
          OP_REMOVE: st_nxt = BS_REMOVE;
          OP_DRAIN:  st_nxt = BS_DRAIN;
          default:   st_nxt = obuf_free ? BS_IDLE : BS_IDLE;
        endcase
      end
      BS_REMOVE: if (!job_r.reinsert || 1'b1) st_nxt = job_r.reinsert ? BS_INSERT
                                                     : (obuf_free ? BS_IDLE : BS_REMOVE);
      BS_INSERT: if (obuf_free) st_nxt = BS_IDLE;
      BS_DRAIN:  if (obuf_free && !head_exp) st_nxt = BS_IDLE;
      default:   st_nxt = BS_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    job_ready = 1'b0;
    job_ld    = 1'b0;
    emit      = 1'b0;
    emit_d    = '0;
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    do_pop    = 1'b0;
    unique case (st_r)
      BS_IDLE: begin
        if (job_data.op == OP_REPORT) begin
          job_ready = obuf_free;
          emit      = job_valid && obuf_free;
          emit_d.status = job_data.status;
          emit_d.last   = 1'b1;
        end else begin
          job_ready = 1'b1;
          job_ld    = job_valid;
        end
      end
      BS_REMOVE: begin
        do_rem = !job_r.reinsert ? obuf_free : 1'b1;
        emit   = !job_r.reinsert && obuf_free;
        emit_d.last = 1'b1;
      end
      BS_INSERT: begin
        do_ins = obuf_free;
        emit   = obuf_free;
        emit_d.last = 1'b1;
      end
      BS_DRAIN: begin
        if (obuf_free) begin
          emit = 1'b1;
          if (head_exp) begin
            do_pop = 1'b1;
            emit_d.expired_valid  = 1'b1;
            emit_d.expired_handle = hnd_r[0];
            emit_d.last = (cnt_r == CNT_W'(1)) || (exp_r[1] > job_r.tval);
          end else begin
            emit = !drained_r;
            emit_d.last = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign clr_valid  = do_pop;
  assign clr_handle = hnd_r[0];
  assign drain_done = (st_r == BS_DRAIN) && (st_nxt == BS_IDLE);

  // Count update
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_ins && cnt_r < CNT_W'(TIMER_SLOTS)) cnt_nxt = cnt_r + 1'b1;
    if ((do_rem && rem_shift[TIMER_SLOTS-1]) || do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  // Shift cells of the chain
  always_ff @(posedge clk) begin
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (do_ins && cnt_r < CNT_W'(TIMER_SLOTS)) begin
        if (SLOT_W'(i) == ins_pos && ins_shift[i]) begin
          hnd_r[i] <= job_r.handle;
          exp_r[i] <= job_r.tval;
        end else if (i > 0 && ins_shift[i] && !(SLOT_W'(i) == ins_pos) && ins_shift[i-1]) begin
          hnd_r[i] <= hnd_r[i-1];
          exp_r[i] <= exp_r[i-1];
        end else if (ins_shift[i] && !le_mask[TIMER_SLOTS-1] && ins_pos == '0 && i == 0) begin
          hnd_r[i] <= job_r.handle;
          exp_r[i] <= job_r.tval;
        end
      end
      if ((do_rem && rem_shift[i]) || do_pop) begin
        if (i + 1 < TIMER_SLOTS) begin
          hnd_r[i] <= hnd_r[(i + 1) % TIMER_SLOTS];
          exp_r[i] <= exp_r[(i + 1) % TIMER_SLOTS];
        end
      end
    end
  end

  // Control registers and output register
  always_ff @(posedge clk) begin
    if (job_ld) job_r <= job_data;
    if (emit) od_r <= emit_d;
    if (!rst_n) begin
      st_r      <= BS_IDLE;
      cnt_r     <= '0;
      ov_r      <= 1'b0;
      drained_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (job_ld) drained_r <= 1'b0;
      else if (do_pop) drained_r <= 1'b1;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule

FILE: design/sorted_expiry_timer_queue.sv
// Top level of the sorted expiry timer queue: front, job queue, back.
// Depends on setq_pkg, setq_front, setq_fifo, setq_back.
//
//  channel | ports                         | moves
//  in      | in_valid/in_ready/in_data     | one command per transfer
//  out     | out_valid/out_ready/out_data  | one result per transfer
//
// Back part: add and delete load in idle, then pass an insert or remove state;
// adjust passes remove then insert; status-only results leave from idle; a
// tick pops one expired head per cycle while the output is free, until the
// head is unexpired. Synchronous active-low reset empties the queue. A stalled
// output holds the back part; the job queue lets the front take up to two more
// commands meanwhile. After a tick the input holds until its drain has finished.
module sorted_expiry_timer_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  setq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output setq_pkg::out_item_t  out_data
);
  import setq_pkg::*;

  logic          fj_valid, fj_ready, bj_valid, bj_ready;
  job_t          fj_data, bj_data;
  logic          clr_valid;
  logic [HW-1:0] clr_handle;
  logic          drain_done;

  setq_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data),
    .clr_valid, .clr_handle, .drain_done
  );

  setq_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj_data),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj_data)
  );

  setq_back u_back (
    .clk, .rst_n,
    .job_valid(bj_valid), .job_ready(bj_ready), .job_data(bj_data),
    .out_valid, .out_ready, .out_data,
    .clr_valid, .clr_handle, .drain_done
  );
endmodule

FILE: design/setq_checker.sv
// Port-level checks for the sorted expiry timer queue, bound to the top.
// Depends on setq_pkg.
module setq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input setq_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input setq_pkg::out_item_t out_data
);
  import setq_pkg::*;

  // A held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Expired reports carry ok status
  a_exp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.expired_valid |-> out_data.status == ST_OK)
    else $error("expired result with error status");

  // Non-expiry results close their item
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.expired_valid |-> out_data.last)
    else $error("status result without last");

  // Nothing comes out straight after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind sorted_expiry_timer_queue setq_checker u_setq_checker (
  .clk, .rst_n, .in_valid, .in_ready, .in_data,
  .out_valid, .out_ready, .out_data
);

FILE: dv/tb.sv
// Testbench for the sorted expiry timer queue: drives commands, predicts results.
// Depends on setq_pkg and the sorted_expiry_timer_queue top level.
`timescale 1ns / 1ps

module tb;
  import setq_pkg::*;

  // Predictor of the timer queue with a store of expected results
  class timer_scoreboard;
    logic [3:0]  slot_handle[16];
    logic [31:0] slot_expiry[16];
    int          slot_count;
    bit          queued[16];
    out_item_t   pending[$];
    int          errors;
    int          results_seen;
    int          expired_seen;

    function void clear();
      slot_count = 0;
      foreach (queued[i]) queued[i] = 0;
      pending.delete();
      errors = 0;
      results_seen = 0;
      expired_seen = 0;
    endfunction

    function void take_out(int pos);
      for (int i = pos; i + 1 < slot_count; i++) begin
        slot_handle[i] = slot_handle[i+1];
        slot_expiry[i] = slot_expiry[i+1];
      end
      slot_count--;
    endfunction

    function void place(logic [3:0] h, logic [31:0] e);
      int pos;
      pos = 0;
      while (pos < slot_count && slot_expiry[pos] <= e) pos++;
      for (int i = slot_count; i > pos; i--) begin
        slot_handle[i] = slot_handle[i-1];
        slot_expiry[i] = slot_expiry[i-1];
      end
      slot_handle[pos] = h;
      slot_expiry[pos] = e;
      slot_count++;
    endfunction

    function void note_command(in_item_t it);
      out_item_t r;
      int n;
      int pos;
      r = '0;
      r.last = 1'b1;
      n = 0;
      if (it.command == CMD_TICK) begin
        // drain every expired head, last flag on the final one
        while (slot_count > 0 && slot_expiry[0] <= it.now_time) begin
          r = '0;
          r.expired_valid = 1'b1;
          r.expired_handle = slot_handle[0];
          queued[slot_handle[0]] = 0;
          take_out(0);
          pending.push_back(r);
          n++;
        end
        if (n == 0) begin
          r = '0;
          r.last = 1'b1;
          pending.push_back(r);
        end else begin
          pending[pending.size()-1].last = 1'b1;
        end
        return;
      end
      if (it.command == CMD_ADD) begin
        if (queued[it.handle]) r.status = ST_QUEUED;
        else begin
          place(it.handle, it.expire_time);
          queued[it.handle] = 1;
        end
      end else if (!queued[it.handle]) begin
        r.status = ST_NOT_Q;
      end else begin
        pos = 0;
        while (pos < slot_count && slot_handle[pos] != it.handle) pos++;
        if (pos < slot_count) take_out(pos);
        if (it.command == CMD_ADJUST) place(it.handle, it.expire_time);
        else queued[it.handle] = 0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.expired_valid) expired_seen++;
      if (got.expired_valid !== want.expired_valid) begin
        $error("expired_valid: expected %0d actual %0d", want.expired_valid, got.expired_valid);
        errors++;
      end
      if (got.expired_handle !== want.expired_handle) begin
        $error("expired_handle: expected %0d actual %0d",
               want.expired_handle, got.expired_handle);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d actual %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  timer_scoreboard timers;
  int send_idle_pct;
  int recv_stall_pct;
  int sent_count;
  logic [31:0] clock_now;

  sorted_expiry_timer_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hold the whole run to a generous ceiling
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Check every result transfer and stall the receiver at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) timers.check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one command and hold it until transferred; valid drops only when idling
  task automatic send_command(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    timers.note_command(it);
    sent_count++;
  endtask

  task automatic send_fields(cmd_t c, logic [3:0] h, logic [31:0] e, logic [31:0] t);
    in_item_t it;
    it.command = c;
    it.handle = h;
    it.expire_time = e;
    it.now_time = t;
    send_command(it);
  endtask

  // Drop valid and wait until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (timers.pending.size() != 0) @(posedge clk);
  endtask

  // Mostly near-future timers with noise; ticks advance a running clock
  task automatic random_command();
    in_item_t it;
    int pick;
    it.command = cmd_t'($urandom_range(3));
    it.handle = $urandom_range(15);
    pick = $urandom_range(9);
    it.expire_time = (pick < 8) ? clock_now + $urandom_range(40) : $urandom;
    it.now_time = (pick < 8) ? clock_now + $urandom_range(20) : $urandom;
    if (it.command == CMD_TICK && pick < 8) clock_now = it.now_time;
    send_command(it);
  endtask

  initial begin
    timers = new();
    timers.clear();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent_count = 0;
    clock_now = 32'd100;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty tick, errors, ties, extremes, adjust down and up
    send_fields(CMD_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF);
    send_fields(CMD_DELETE, 4'd3, 32'd0, 32'd0);
    send_fields(CMD_ADJUST, 4'd4, 32'd5, 32'd0);
    send_fields(CMD_ADD, 4'd0, 32'hFFFF_FFFF, 32'd0);
    send_fields(CMD_ADD, 4'd0, 32'd1, 32'd0);
    send_fields(CMD_ADD, 4'd15, 32'd0, 32'd0);
    send_fields(CMD_ADD, 4'd5, 32'd10, 32'd0);
    send_fields(CMD_ADD, 4'd6, 32'd10, 32'd0);
    send_fields(CMD_ADD, 4'd7, 32'd10, 32'd0);
    send_fields(CMD_ADJUST, 4'd7, 32'd2, 32'd0);
    send_fields(CMD_ADJUST, 4'd5, 32'd20, 32'd0);
    send_fields(CMD_DELETE, 4'd6, 32'd0, 32'hFFFF_FFFF);
    send_fields(CMD_TICK, 4'd9, 32'hFFFF_FFFF, 32'd10);
    for (int h = 0; h < 16; h++) send_fields(CMD_ADD, h[3:0], 32'd50, 32'd0);
    send_fields(CMD_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF);
    wait_drained();

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 77 : (ph == 3) ? 11 : 0;
      recv_stall_pct = (ph == 2) ? 77 : (ph == 3) ? 11 : 0;
      for (int k = 0; k < 85; k++) begin
        random_command();
        if (k == 50) wait_drained();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_fields(CMD_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF);

    wait_drained();
    repeat (40) @(posedge clk);
    $display("Ran %0d commands, checked %0d results, %0d of them expiries.",
             sent_count, timers.results_seen, timers.expired_seen);
    if (timers.errors == 0 && timers.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
